FILE: hdl/rmth_pkg.sv
// Shared constants and the chain operation codes of the running median block.
package rmth_pkg;

  localparam int unsigned CAPACITY_DEF    = 1024;
  localparam int unsigned SAMPLE_BITS_DEF = 32;
  localparam int unsigned IN_W            = 32;
  localparam int unsigned MED_W           = 33;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_POP,
    OP_SWAP
  } rmth_op_e;

endpackage

FILE: hdl/rmth_cell.sv
// One cell of a sorted chain: holds one sample and shifts with its neighbors.
module rmth_cell import rmth_pkg::*; #(
  parameter int unsigned SW   = SAMPLE_BITS_DEF,
  parameter int unsigned CW   = 10,
  parameter int unsigned IDX  = 0,
  parameter bit          DESC = 1'b0
) (
  input  logic                 clk_i,
  input  rmth_op_e             op_i,
  input  logic signed [SW-1:0] x_i,
  input  logic [CW-1:0]        count_i,
  input  logic signed [SW-1:0] left_val_i,
  input  logic                 left_before_i,
  input  logic signed [SW-1:0] right_val_i,
  input  logic                 right_before_i,
  output logic signed [SW-1:0] val_o,
  output logic                 before_o
);

  logic signed [SW-1:0] val_q;
  logic signed [SW-1:0] val_d;
  logic                 occupied;
  logic                 precedes;

  assign occupied = CW'(IDX) < count_i;
  assign precedes = DESC ? (x_i > val_q) : (x_i < val_q);
  assign before_o = !occupied || precedes;
  assign val_o    = val_q;

  always_comb begin
    unique case (op_i)
      OP_INSERT: val_d = left_before_i ? left_val_i : (before_o ? x_i : val_q);
      OP_POP:    val_d = right_val_i;
      OP_SWAP:   val_d = before_o ? val_q : (right_before_i ? x_i : right_val_i);
      default:   val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

FILE: hdl/rmth_chain.sv
// A sorted chain of cells with its extreme value at cell zero.
module rmth_chain import rmth_pkg::*; #(
  parameter int unsigned DEPTH = CAPACITY_DEF / 2,
  parameter int unsigned SW    = SAMPLE_BITS_DEF,
  parameter int unsigned CW    = $clog2(DEPTH + 1),
  parameter bit          DESC  = 1'b0
) (
  input  logic                 clk_i,
  input  rmth_op_e             op_i,
  input  logic signed [SW-1:0] x_i,
  input  logic [CW-1:0]        count_i,
  output logic signed [SW-1:0] head_o
);

  logic signed [SW-1:0] val   [DEPTH];
  logic                 bef   [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [SW-1:0] lv;
    logic                 lb;
    logic signed [SW-1:0] rv;
    logic                 rb;

    if (i == 0) begin : g_first
      assign lv = '0;
      assign lb = 1'b0;
    end else begin : g_mid_l
      assign lv = val[i-1];
      assign lb = bef[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign rv = val[i];
      assign rb = 1'b1;
    end else begin : g_mid_r
      assign rv = val[i+1];
      assign rb = bef[i+1];
    end

    rmth_cell #(
      .SW   (SW),
      .CW   (CW),
      .IDX  (i),
      .DESC (DESC)
    ) u_cell (
      .clk_i          (clk_i),
      .op_i           (op_i),
      .x_i            (x_i),
      .count_i        (count_i),
      .left_val_i     (lv),
      .left_before_i  (lb),
      .right_val_i    (rv),
      .right_before_i (rb),
      .val_o          (val[i]),
      .before_o       (bef[i])
    );
  end

  assign head_o = val[0];

endmodule

FILE: hdl/running_median_two_heap.sv
// Top level of the running median block built from two sorted cell chains.
//
// The samples are split into a lower half (a chain sorted with its largest value
// at the head) and an upper half (a chain sorted with its smallest value at the
// head). In the cycle of a sample's transfer the chains insert it or swap their
// heads in parallel; in the REPORT state the doubled median is then formed from
// the chain heads into the output register, which waits while the output is
// stalled. The block takes the next sample once that result has moved into the
// output register, so a stalled output holds off the input. There is no
// clearing pass after reset. Once CAPACITY samples are held, further samples
// are dropped, flagged, and the last median is repeated.
module running_median_two_heap import rmth_pkg::*; #(
  parameter int unsigned CAPACITY    = CAPACITY_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int unsigned CNT_W      = $clog2(CAPACITY + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [IN_W-1:0]  sample_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [MED_W-1:0] median_doubled_o,
  output logic [CNT_W-1:0]        sample_count_o,
  output logic                    dropped_o
);

  localparam int unsigned SW       = SAMPLE_BITS;
  localparam int unsigned LO_DEPTH = (CAPACITY + 1) / 2;
  localparam int unsigned UP_DEPTH = CAPACITY / 2;
  localparam int unsigned LCW      = $clog2(LO_DEPTH + 1);
  localparam int unsigned UCW      = $clog2(UP_DEPTH + 1);

  typedef enum logic {
    ST_IDLE,
    ST_REPORT
  } state_e;

  state_e               state_q;
  logic                 out_valid_q;
  logic signed [MED_W-1:0] median_q;
  logic [CNT_W-1:0]     count_out_q;
  logic                 dropped_q;
  logic                 drop_pend_q;
  logic [LCW-1:0]       lo_cnt_q;
  logic [LCW-1:0]       lo_cnt_d;
  logic [UCW-1:0]       up_cnt_q;
  logic [UCW-1:0]       up_cnt_d;

  logic                 accept;
  logic                 full;
  logic [CNT_W-1:0]     total;
  logic signed [SW-1:0] x;
  logic signed [SW-1:0] lo_head;
  logic signed [SW-1:0] up_head;
  rmth_op_e             lo_op;
  rmth_op_e             up_op;
  logic signed [SW-1:0] lo_x;
  logic signed [SW-1:0] up_x;
  logic                 lo_bigger;
  logic                 load_out;
  logic signed [SW:0]   med_sum;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign x          = sample_i[SW-1:0];
  assign total      = CNT_W'(lo_cnt_q) + CNT_W'(up_cnt_q);
  assign full       = total >= CNT_W'(CAPACITY);
  assign lo_bigger  = LCW'(up_cnt_q) < lo_cnt_q;

  always_comb begin
    lo_op    = OP_HOLD;
    up_op    = OP_HOLD;
    lo_x     = x;
    up_x     = x;
    lo_cnt_d = lo_cnt_q;
    up_cnt_d = up_cnt_q;
    if (accept && !full) begin
      priority if (lo_cnt_q == '0) begin
        lo_op    = OP_INSERT;
        lo_cnt_d = lo_cnt_q + 1'b1;
      end else if (lo_bigger) begin
        up_cnt_d = up_cnt_q + 1'b1;
        if (lo_head > x) begin
          lo_op = OP_SWAP;
          up_op = OP_INSERT;
          up_x  = lo_head;
        end else begin
          up_op = OP_INSERT;
        end
      end else begin
        lo_cnt_d = lo_cnt_q + 1'b1;
        lo_op    = OP_INSERT;
        if (lo_head < x && !(x < up_head)) begin
          up_op = OP_SWAP;
          lo_x  = up_head;
        end
      end
    end
  end

  rmth_chain #(
    .DEPTH (LO_DEPTH),
    .SW    (SW),
    .CW    (LCW),
    .DESC  (1'b1)
  ) u_lower (
    .clk_i   (clk_i),
    .op_i    (lo_op),
    .x_i     (lo_x),
    .count_i (lo_cnt_q),
    .head_o  (lo_head)
  );

  rmth_chain #(
    .DEPTH (UP_DEPTH),
    .SW    (SW),
    .CW    (UCW),
    .DESC  (1'b0)
  ) u_upper (
    .clk_i   (clk_i),
    .op_i    (up_op),
    .x_i     (up_x),
    .count_i (up_cnt_q),
    .head_o  (up_head)
  );

  assign load_out = (state_q == ST_REPORT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    priority if (lo_cnt_q == '0) begin
      med_sum = '0;
    end else if (lo_bigger) begin
      med_sum = $signed({lo_head, 1'b0});
    end else begin
      med_sum = (SW + 1)'(lo_head) + (SW + 1)'(up_head);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      lo_cnt_q    <= '0;
      up_cnt_q    <= '0;
    end else begin
      lo_cnt_q <= lo_cnt_d;
      up_cnt_q <= up_cnt_d;
      unique case (state_q)
        ST_IDLE: begin
          if (out_valid_q && !out_stall_i) begin
            out_valid_q <= 1'b0;
          end
          if (accept) begin
            state_q <= ST_REPORT;
          end
        end
        ST_REPORT: begin
          if (load_out) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      drop_pend_q <= full;
    end
    if (load_out) begin
      median_q    <= MED_W'(med_sum);
      count_out_q <= total;
      dropped_q   <= drop_pend_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign median_doubled_o = median_q;
  assign sample_count_o   = count_out_q;
  assign dropped_o        = dropped_q;

  a_halves_balanced : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (LCW'(up_cnt_q) <= lo_cnt_q) && (lo_cnt_q <= LCW'(up_cnt_q) + 1'b1))
    else $error("lower and upper halves out of balance");

  a_drop_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && dropped_o) |-> (sample_count_o == CNT_W'(CAPACITY)))
    else $error("sample dropped while the store was not full");

  a_count_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (sample_count_o != '0))
    else $error("result reported with an empty store");

  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_stall_o)
    else $error("input not held off while a sample is being reported");

endmodule
